// ===== rtl/pfls_pkg.sv =====
// ----------------------------------------------------------------------------
// pfls_pkg
// Shared types and constants of the polyline fixed-length splitter.
// ----------------------------------------------------------------------------
package pfls_pkg;

    // one polyline vertex
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               final_vertex;
    } t_vtx;

    // one reported point
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [15:0]        piece_number;
        logic [1:0]         point_kind;
        logic               cut_overflow;
        logic               run_end;
    } t_pt;

    localparam logic [1:0] KIND_FIRST    = 2'd0;
    localparam logic [1:0] KIND_INTERIOR = 2'd1;
    localparam logic [1:0] KIND_CUT      = 2'd2;
    localparam logic [1:0] KIND_END      = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 31;
    localparam logic [0:0] REG_PIECE_LENGTH = 1'd0;
    localparam logic [0:0] REG_TOLERANCE    = 1'd1;

    localparam logic [15:0] PIECE_MAX = 16'hFFFF;
    localparam int          CUT_W     = 6;

    // step counts of the shared iterative units
    localparam logic [6:0] ROOT_STEPS = 7'd33;
    localparam logic [6:0] LEN_STEPS  = 7'd34;
    localparam logic [6:0] PROD_STEPS = 7'd66;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       first_done;
        logic       sq_mul;
        logic       sq_load;
        logic       sq_step;
        logic       div_load_len;
        logic       div_load_prod;
        logic       div_step;
        logic       div_end;
        logic       cut_mul;
        logic       cut_round;
        logic       cut_adv;
        logic       axis;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
        logic       finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic             has_prev;
        logic             fin;
        logic             out_free;
        logic             emit_end;
        logic [CUT_W-1:0] ncuts;
    } t_sts;

endpackage

// ===== rtl/pfls_chan_if.sv =====
// ----------------------------------------------------------------------------
// pfls_chan_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface pfls_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pfls_dp.sv =====
// ----------------------------------------------------------------------------
// pfls_dp
// Datapath: config registers, line state, shared root and divide units,
// cut interpolation and the output register.
// ----------------------------------------------------------------------------
module pfls_dp #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_CUTS  = 62
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfls_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfls_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  pfls_pkg::t_vtx                 i_vtx,
    input  pfls_pkg::t_cmd                 i_cmd,
    output pfls_pkg::t_sts                 o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output pfls_pkg::t_pt                  o_out
);
    import pfls_pkg::*;

    localparam logic [30:0] LEN_RST = 31'(1 << FRAC_BITS);
    localparam int          TOL_RAW = ((1 << FRAC_BITS) + 50) / 100;
    localparam logic [15:0] TOL_RST = (TOL_RAW > 65535) ? 16'hFFFF : 16'(TOL_RAW);

    logic [30:0]        r_plen;
    logic [15:0]        r_tol;
    logic               r_has_prev;
    logic signed [31:0] r_prev_x, r_prev_y;
    logic [30:0]        r_carry;
    logic [15:0]        r_piece;

    logic signed [31:0] r_x, r_y;
    logic               r_fin;
    logic [31:0]        r_ax, r_ay;
    logic               r_nx, r_ny;
    logic [63:0]        r_sx, r_sy;
    logic [65:0]        r_rad;
    logic [34:0]        r_srem;
    logic [32:0]        r_root;
    logic [65:0]        r_dq;
    logic [33:0]        r_drem;
    logic [32:0]        r_dd;
    logic [65:0]        r_prod;
    logic [CUT_W-1:0]   r_ncuts;
    logic               r_ovf;
    logic [30:0]        r_cnew;
    logic               r_emit_end;
    logic [15:0]        r_piece_nx;
    logic [15:0]        r_cpiece;
    logic signed [38:0] r_t;
    logic signed [31:0] r_cx, r_cy;
    logic               r_ov;
    t_pt                r_out;

    logic [30:0]        w_len;
    logic signed [32:0] w_dx, w_dy;
    logic [36:0]        w_rem_s, w_trial;
    logic               w_sge;
    logic [34:0]        w_drs;
    logic               w_dge;
    logic [33:0]        w_total;
    logic [33:0]        w_n;
    logic               w_novf;
    logic [34:0]        w_psum;
    logic [32:0]        w_tu;
    logic [31:0]        w_a;
    logic [32:0]        w_q;
    logic signed [31:0] w_base, w_c;
    logic               w_neg;

    // piece length of zero acts as one
    assign w_len = (r_plen == 31'd0) ? 31'd1 : r_plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= LEN_RST;
            r_tol  <= TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PIECE_LENGTH: r_plen <= i_cfg_data;
                REG_TOLERANCE:    r_tol  <= i_cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign w_dx = 33'(i_vtx.point_x) - 33'(r_prev_x);
    assign w_dy = 33'(i_vtx.point_y) - 33'(r_prev_y);

    assign w_rem_s = {r_srem, r_rad[65:64]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = (w_rem_s >= w_trial);

    assign w_drs = {r_drem, r_dq[65]};
    assign w_dge = (w_drs >= {2'b00, r_dd});

    assign w_total = 34'(r_carry) + 34'(r_root);
    assign w_n     = r_dq[33:0];
    assign w_novf  = (w_n > 34'(MAX_CUTS));
    assign w_psum  = 35'(r_piece) + 35'(w_n);

    // clamp the cut offset into the segment
    always_comb begin
        if (r_t[38])
            w_tu = 33'd0;
        else if (r_t > $signed({6'd0, r_root}))
            w_tu = r_root;
        else
            w_tu = r_t[32:0];
    end

    assign w_a    = i_cmd.axis ? r_ay : r_ax;
    assign w_neg  = i_cmd.axis ? r_ny : r_nx;
    assign w_base = i_cmd.axis ? r_prev_y : r_prev_x;
    assign w_q    = (r_root == 33'd0) ? 33'd0 :
                    r_dq[32:0] + 33'({r_drem, 1'b0} >= {2'b00, r_dd});
    assign w_c    = w_neg ? w_base - $signed(w_q[31:0]) : w_base + $signed(w_q[31:0]);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_x   <= i_vtx.point_x;
            r_y   <= i_vtx.point_y;
            r_fin <= i_vtx.final_vertex;
            r_nx  <= w_dx[32];
            r_ny  <= w_dy[32];
            r_ax  <= w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
            r_ay  <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
        end
        if (i_cmd.sq_mul) begin
            r_sx <= 64'(r_ax) * 64'(r_ax);
            r_sy <= 64'(r_ay) * 64'(r_ay);
        end
        if (i_cmd.sq_load) begin
            r_rad  <= 66'(r_sx) + 66'(r_sy);
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad <= {r_rad[63:0], 2'b00};
            if (w_sge) begin
                r_srem <= 35'(w_rem_s - w_trial);
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_srem <= w_rem_s[34:0];
                r_root <= {r_root[31:0], 1'b0};
            end
        end
        if (i_cmd.div_load_len) begin
            r_dq   <= {w_total, 32'd0};
            r_drem <= '0;
            r_dd   <= {2'b00, w_len};
        end else if (i_cmd.div_load_prod) begin
            r_dq   <= r_prod;
            r_drem <= '0;
            r_dd   <= r_root;
        end else if (i_cmd.div_step) begin
            r_dq   <= {r_dq[64:0], w_dge};
            r_drem <= w_dge ? 34'(w_drs - {2'b00, r_dd}) : w_drs[33:0];
        end
        if (i_cmd.div_end) begin
            r_ncuts    <= w_novf ? CUT_W'(MAX_CUTS) : w_n[CUT_W-1:0];
            r_ovf      <= w_novf;
            r_cnew     <= r_drem[30:0];
            r_emit_end <= (r_drem[30:0] > {15'd0, r_tol});
            r_piece_nx <= (w_psum > 35'(PIECE_MAX)) ? PIECE_MAX : w_psum[15:0];
            r_cpiece   <= r_piece;
            r_t        <= $signed({8'd0, w_len}) - $signed({8'd0, r_carry});
        end else if (i_cmd.cut_adv) begin
            r_t      <= r_t + $signed({8'd0, w_len});
            r_cpiece <= (r_cpiece == PIECE_MAX) ? PIECE_MAX : r_cpiece + 16'd1;
        end
        if (i_cmd.cut_mul)
            r_prod <= 66'(w_a) * 66'(w_tu);
        if (i_cmd.cut_round) begin
            if (i_cmd.axis)
                r_cy <= w_c;
            else
                r_cx <= w_c;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev <= 1'b0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_carry    <= '0;
            r_piece    <= '0;
        end else if (i_cmd.first_done) begin
            r_carry    <= '0;
            r_piece    <= '0;
            r_has_prev <= !r_fin;
            if (!r_fin) begin
                r_prev_x <= r_x;
                r_prev_y <= r_y;
            end
        end else if (i_cmd.finish) begin
            if (r_fin) begin
                r_has_prev <= 1'b0;
                r_prev_x   <= '0;
                r_prev_y   <= '0;
                r_carry    <= '0;
                r_piece    <= '0;
            end else begin
                r_prev_x <= r_x;
                r_prev_y <= r_y;
                r_carry  <= r_cnew;
                r_piece  <= r_piece_nx;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.point_kind <= i_cmd.emit_kind;
            r_out.run_end    <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                KIND_FIRST: begin
                    r_out.out_x        <= r_x;
                    r_out.out_y        <= r_y;
                    r_out.piece_number <= '0;
                    r_out.cut_overflow <= 1'b0;
                end
                KIND_CUT: begin
                    r_out.out_x        <= r_cx;
                    r_out.out_y        <= r_cy;
                    r_out.piece_number <= r_cpiece;
                    r_out.cut_overflow <= r_ovf;
                end
                default: begin
                    r_out.out_x        <= r_x;
                    r_out.out_y        <= r_y;
                    r_out.piece_number <= r_piece_nx;
                    r_out.cut_overflow <= r_ovf;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out          = r_out;
    assign o_sts.has_prev = r_has_prev;
    assign o_sts.fin      = r_fin;
    assign o_sts.out_free = !r_ov || i_out_ready;
    assign o_sts.emit_end = r_emit_end;
    assign o_sts.ncuts    = r_ncuts;

endmodule

// ===== rtl/pfls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfls_ctrl
// Controller: sequences root, divide, cut and emit steps for one vertex.
// ----------------------------------------------------------------------------
module pfls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pfls_pkg::t_sts i_sts,
    output pfls_pkg::t_cmd o_cmd
);
    import pfls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_SQMUL, S_SQLOAD, S_SQRT, S_DIVLD, S_DIV, S_DIVEND,
        S_CHECK, S_CUTMUL, S_CUTLD, S_MDIV, S_ROUND, S_CUTEMIT, S_ENDEMIT, S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [6:0]       r_cnt, n_cnt;
    logic [CUT_W-1:0] r_k, n_k;
    logic             r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_sts.has_prev ? S_SQMUL : S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_kind  = KIND_FIRST;
                    o_cmd.emit_last  = 1'b1;
                    o_cmd.first_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SQMUL: begin
                o_cmd.sq_mul = 1'b1;
                n_state = S_SQLOAD;
            end
            S_SQLOAD: begin
                o_cmd.sq_load = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == ROOT_STEPS - 7'd1)
                    n_state = S_DIVLD;
            end
            S_DIVLD: begin
                o_cmd.div_load_len = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == LEN_STEPS - 7'd1)
                    n_state = S_DIVEND;
            end
            S_DIVEND: begin
                o_cmd.div_end = 1'b1;
                n_k     = '0;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_axis = 1'b0;
                if (r_k < i_sts.ncuts)
                    n_state = S_CUTMUL;
                else if (i_sts.emit_end)
                    n_state = S_ENDEMIT;
                else
                    n_state = S_FINISH;
            end
            S_CUTMUL: begin
                o_cmd.cut_mul = 1'b1;
                n_state = S_CUTLD;
            end
            S_CUTLD: begin
                o_cmd.div_load_prod = 1'b1;
                n_cnt   = '0;
                n_state = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == PROD_STEPS - 7'd1)
                    n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.cut_round = 1'b1;
                if (r_axis) begin
                    n_state = S_CUTEMIT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_CUTMUL;
                end
            end
            S_CUTEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_CUT;
                    o_cmd.emit_last = (r_k == i_sts.ncuts - CUT_W'(1)) && !i_sts.emit_end;
                    o_cmd.cut_adv   = 1'b1;
                    n_k     = r_k + CUT_W'(1);
                    n_state = S_CHECK;
                end
            end
            S_ENDEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = i_sts.fin ? KIND_END : KIND_INTERIOR;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_axis  <= n_axis;
        end
    end

endmodule

// ===== rtl/polyline_fixed_length_splitter.sv =====
// ----------------------------------------------------------------------------
// polyline_fixed_length_splitter
// Splits a polyline into pieces of fixed arc length and reports cut points.
// ----------------------------------------------------------------------------
// Vertices arrive one transaction at a time on i_vtx; reported points leave on
// o_pt. One vertex is in work at a time. A later vertex goes through accept,
// setup, a 33-step square root and a 34-step divide on the shared divide unit,
// check and close, plus a step when the vertex itself is reported, plus a
// multiply and a 66-step divide per axis for each cut point shown, plus output
// stall time. The output register lets one finished point wait while the next
// is computed. Configuration on i_cfg_* must be written only while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module polyline_fixed_length_splitter #(
    parameter int MAX_CUTS  = 62,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pfls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pfls_chan_if.sink                        i_vtx,
    pfls_chan_if.source                      o_pt
);
    import pfls_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;
    t_pt  w_out;

    // controller: accepts a vertex only when idle, then steps the datapath
    pfls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: holds line state, arithmetic units and the output register
    pfls_dp #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_CUTS  (MAX_CUTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_vtx       (i_vtx.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_pt.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign i_vtx.ready = w_in_ready;
    assign o_pt.valid  = w_out_valid;
    assign o_pt.data   = w_out;

endmodule

// ===== rtl/pfls_checker.sv =====
// ----------------------------------------------------------------------------
// pfls_checker
// Port-level checks of the splitter, bound to the top level.
// ----------------------------------------------------------------------------
module pfls_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input pfls_pkg::t_pt i_out_data
);
    import pfls_pkg::*;

    // hold a stalled output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output dropped or changed");

    // one vertex in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a vertex is in work");

    // a first vertex stands alone and never overflows
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.point_kind == KIND_FIRST
        |-> i_out_data.run_end && !i_out_data.cut_overflow)
        else $error("bad first vertex result");

    // the end point closes the run
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.point_kind == KIND_END |-> i_out_data.run_end)
        else $error("end point without run end");

endmodule

bind polyline_fixed_length_splitter pfls_checker u_pfls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_out_data  (o_pt.data)
);
